### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Op codes, error codes, cell commands, cell link and payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int WORD_W    = 32;
    localparam int OP_W      = 3;
    localparam int ERR_W     = 2;
    localparam int COUNT_W   = 8;
    localparam int DEPTH_DEF = 128;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY      = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } t_err;

    // per-chain command, broadcast to every cell
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INS_HEAD,
        CMD_REM_HEAD,
        CMD_ADD_TAIL,
        CMD_DROP_TAIL,
        CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        logic              v;
        logic [WORD_W-1:0] d;
    } t_cell_link;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic signed [WORD_W-1:0] value;
    } t_deq_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic                     popped_valid;
        logic [ERR_W-1:0]         error;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } t_deq_out;

endpackage

`default_nettype wire

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Two mirrored cell chains keep both ends at a fixed cell; one op per cycle unless the sink stalls.
// ----------------------------------------------------------------------------
// Each request carries one op (query, push front/back, pop front/back, clear;
// codes 6 and 7 act as a query) and returns exactly one response with the
// popped word, an error code (overflow on push when full, underflow on pop
// when empty; the queue is then left as it was), and front, back, count and
// empty flag after the op. Front and back read all ones when empty. Storage
// is two rows of DEPTH cells: row A holds the words front first, row B holds
// them back first, so both ends always sit in cell 0 of a row and every cell
// only talks to its neighbors. A push at one end shifts that end's row and
// appends at the tail of the other row; a pop does the reverse. Throughput
// is one request per cycle unless the sink stalls; the response is registered.
// The response register holds a result while the sink stalls and the next
// request is taken in the same cycle the response leaves. No clearing pass
// is needed after reset. Count reports the low 8 bits of the true count.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_deq_in  i_req,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_deq_out      o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // occupancy
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // response register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_popped;
    logic [WORD_W-1:0] n_popped;
    logic              r_popped_valid;
    logic              n_popped_valid;
    logic [ERR_W-1:0]  r_err;
    t_err              n_err;

    t_cmd       w_cmd_a;   // front-first row
    t_cmd       w_cmd_b;   // back-first row
    t_cell_link w_head_a;
    t_cell_link w_head_b;
    logic       w_full_a;
    logic       w_full_b;
    logic       w_accept;
    logic       w_is_full;
    logic       w_is_empty;
    logic [CW+COUNT_W-1:0] w_count_ext;

    // next request enters as soon as the pending response leaves
    assign o_ready    = !r_out_valid || i_ready;
    assign w_accept   = i_valid && o_ready;
    assign w_is_full  = (r_count == FULL_CNT);
    assign w_is_empty = (r_count == '0);

    // op decode: row commands, count update and response fields
    always_comb begin
        w_cmd_a        = CMD_HOLD;
        w_cmd_b        = CMD_HOLD;
        n_count        = r_count;
        n_err          = ERR_NONE;
        n_popped       = '0;
        n_popped_valid = 1'b0;
        if (w_accept) begin
            unique case (i_req.op)
                OP_PUSH_FRONT: begin
                    if (w_is_full) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        w_cmd_a = CMD_INS_HEAD;
                        w_cmd_b = CMD_ADD_TAIL;
                        n_count = r_count + CW'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (w_is_full) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        w_cmd_a = CMD_ADD_TAIL;
                        w_cmd_b = CMD_INS_HEAD;
                        n_count = r_count + CW'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (w_is_empty) begin
                        n_err = ERR_UNDERFLOW;
                    end else begin
                        w_cmd_a        = CMD_REM_HEAD;
                        w_cmd_b        = CMD_DROP_TAIL;
                        n_count        = r_count - CW'(1);
                        n_popped       = w_head_a.d;
                        n_popped_valid = 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (w_is_empty) begin
                        n_err = ERR_UNDERFLOW;
                    end else begin
                        w_cmd_a        = CMD_DROP_TAIL;
                        w_cmd_b        = CMD_REM_HEAD;
                        n_count        = r_count - CW'(1);
                        n_popped       = w_head_b.d;
                        n_popped_valid = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    w_cmd_a = CMD_CLEAR;
                    w_cmd_b = CMD_CLEAR;
                    n_count = '0;
                end
                default: ;  // query and unused codes
            endcase
        end
    end

    deq_chain #(.DEPTH(DEPTH)) u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_a),
        .i_value (i_req.value),
        .o_head  (w_head_a),
        .o_full  (w_full_a)
    );

    deq_chain #(.DEPTH(DEPTH)) u_chain_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_b),
        .i_value (i_req.value),
        .o_head  (w_head_b),
        .o_full  (w_full_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped       <= n_popped;
            r_popped_valid <= n_popped_valid;
            r_err          <= n_err;
        end
    end

    // front/back from the rows, count/empty from r_count; all move only on accept
    assign w_count_ext = {{COUNT_W{1'b0}}, r_count};
    assign o_valid     = r_out_valid;

    always_comb begin
        o_rsp.popped_value = r_popped;
        o_rsp.popped_valid = r_popped_valid;
        o_rsp.error        = r_err;
        o_rsp.front_value  = w_is_empty ? '1 : w_head_a.d;
        o_rsp.back_value   = w_is_empty ? '1 : w_head_b.d;
        o_rsp.count        = w_count_ext[COUNT_W-1:0];
        o_rsp.is_empty     = w_is_empty;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("count above depth");

    a_rows_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_head_a.v == w_head_b.v) && (w_full_a == w_full_b))
        else $error("front and back rows disagree on occupancy");

    a_count_matches_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_is_empty == !w_head_a.v) && (w_is_full == w_full_a))
        else $error("count out of step with cell valid bits");

    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (n_err != ERR_NONE)) |=> $stable(r_count))
        else $error("failed op changed the count");

endmodule

`default_nettype wire

### rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell: one storage cell of a shifting word chain
// Holds one word and its valid bit; moves data from either neighbor or loads the new word.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell
    import deq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [WORD_W-1:0] i_value,
    input  wire t_cell_link        i_left,
    input  wire t_cell_link        i_right,
    output t_cell_link             o_state
);

    logic              r_v;
    logic              n_v;
    logic [WORD_W-1:0] r_d;
    logic [WORD_W-1:0] n_d;

    always_comb begin
        n_v = r_v;
        n_d = r_d;
        case (i_cmd)
            CMD_INS_HEAD: begin
                n_v = i_left.v;
                n_d = i_left.d;
            end
            CMD_REM_HEAD: begin
                n_v = i_right.v;
                n_d = i_right.d;
            end
            CMD_ADD_TAIL: begin
                // first free cell behind an occupied one takes the word
                if (!r_v && i_left.v) begin
                    n_v = 1'b1;
                    n_d = i_value;
                end
            end
            CMD_DROP_TAIL: begin
                if (r_v && !i_right.v) begin
                    n_v = 1'b0;
                end
            end
            CMD_CLEAR: n_v = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_state = '{v: r_v, d: r_d};

endmodule

`default_nettype wire

### rtl/deq_chain.sv
// ----------------------------------------------------------------------------
// deq_chain: row of DEPTH cells, head at cell 0
// Packed from the head; insert/remove shift the row, tail ops act locally.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_chain
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [WORD_W-1:0] i_value,
    output t_cell_link             o_head,
    output logic                   o_full
);

    t_cell_link w_link [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;

        if (g == 0) begin : g_first
            // head end: new word enters here, counts as occupied for tail add
            assign w_left = '{v: 1'b1, d: i_value};
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '{v: 1'b0, d: '0};
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        deq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_state (w_link[g])
        );
    end

    assign o_head = w_link[0];
    assign o_full = w_link[DEPTH-1].v;

endmodule

`default_nettype wire

### sim/double_ended_queue_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_test: self-checking bench for the double-ended queue
// Drives push, pop, query, clear and spare op codes through the request
// channel. A shadow deque predicts every response, which is checked field by
// field. Sender bursts, sink stalls and one long sink hold-off add pressure.
// ----------------------------------------------------------------------------

module double_ended_queue_test;
    import deq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEF;

    // spare op codes, both behave as a query
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // notable words
    localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] WORD_ONES = 32'hffff_ffff;

    localparam int LONG_HOLD = 300;     // sink hold-off, in cycles

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_deq_in  i_req   = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_deq_out o_rsp;

    double_ended_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow deque: circular buffer with head slot and fill count
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0] sh_words [DEPTH];
    int                sh_head = 0;
    int                sh_fill = 0;

    t_deq_out rsp_expect_q[$];
    int       fail_cnt = 0;

    // apply one request to the shadow deque, return the response it implies
    function automatic t_deq_out deque_apply(input t_deq_in req);
        t_deq_out rsp;
        rsp = '0;
        case (req.op)
            OP_PUSH_FRONT: begin
                if (sh_fill >= DEPTH) begin
                    rsp.error = ERR_OVERFLOW;
                end else begin
                    sh_head = (sh_head + DEPTH - 1) % DEPTH;
                    sh_words[sh_head] = req.value;
                    sh_fill++;
                end
            end
            OP_PUSH_BACK: begin
                if (sh_fill >= DEPTH) begin
                    rsp.error = ERR_OVERFLOW;
                end else begin
                    sh_words[(sh_head + sh_fill) % DEPTH] = req.value;
                    sh_fill++;
                end
            end
            OP_POP_FRONT: begin
                if (sh_fill == 0) begin
                    rsp.error = ERR_UNDERFLOW;
                end else begin
                    rsp.popped_value = sh_words[sh_head];
                    rsp.popped_valid = 1'b1;
                    sh_head = (sh_head + 1) % DEPTH;
                    sh_fill--;
                end
            end
            OP_POP_BACK: begin
                if (sh_fill == 0) begin
                    rsp.error = ERR_UNDERFLOW;
                end else begin
                    rsp.popped_value = sh_words[(sh_head + sh_fill - 1) % DEPTH];
                    rsp.popped_valid = 1'b1;
                    sh_fill--;
                end
            end
            OP_CLEAR: begin
                // contents stay, only the pointers go back
                sh_head = 0;
                sh_fill = 0;
            end
            default: ;  // query and spare codes
        endcase
        rsp.count = COUNT_W'(sh_fill);
        if (sh_fill == 0) begin
            rsp.front_value = WORD_ONES;
            rsp.back_value  = WORD_ONES;
            rsp.is_empty    = 1'b1;
        end else begin
            rsp.front_value = sh_words[sh_head];
            rsp.back_value  = sh_words[(sh_head + sh_fill - 1) % DEPTH];
        end
        return rsp;
    endfunction

    task automatic field_check(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predict on request accept, check on response accept.
    // The response is registered, so a response never belongs to the request
    // taken at the same edge; checking first keeps the queue order plain.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_deq_out exp_rsp;
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_ready) begin
                if (rsp_expect_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("response with nothing pending: %h", o_rsp);
                end else begin
                    exp_rsp = rsp_expect_q[0];
                    rsp_expect_q.delete(0);
                    field_check("popped_value", exp_rsp.popped_value, o_rsp.popped_value);
                    field_check("popped_valid", exp_rsp.popped_valid, o_rsp.popped_valid);
                    field_check("error", exp_rsp.error, o_rsp.error);
                    field_check("front_value", exp_rsp.front_value, o_rsp.front_value);
                    field_check("back_value", exp_rsp.back_value, o_rsp.back_value);
                    field_check("count", exp_rsp.count, o_rsp.count);
                    field_check("is_empty", exp_rsp.is_empty, o_rsp.is_empty);
                end
            end
            if (i_valid && o_ready === 1'b1)
                rsp_expect_q.insert(rsp_expect_q.size(), deque_apply(i_req));
        end
    end

    // ------------------------------------------------------------------------
    // Sink: draws a new stall pattern whenever the current one runs out; a long
    // hold-off starts whenever the test bumps hold_gen.
    // ------------------------------------------------------------------------
    int sink_mode      = 0;
    int sink_mode_left = 0;
    int hold_gen       = 0;     // written by the test only
    int hold_seen      = 0;
    int hold_left      = 0;

    always @(posedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode      <= $urandom_range(0, 3);
            sink_mode_left <= $urandom_range(16, 96);
        end else begin
            sink_mode_left <= sink_mode_left - 1;
        end

        if (hold_gen != hold_seen) begin
            hold_seen <= hold_gen;
            hold_left <= LONG_HOLD;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            case (sink_mode)
                0: i_ready <= 1'b1;                             // no stalls
                1: i_ready <= ($urandom_range(0, 3) != 0);      // light
                2: i_ready <= ($urandom_range(0, 9) < 3);       // heavy
                default: i_ready <= ~i_ready;                   // alternating
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Source: bursts of random length with random gaps in between.
    // valid stays high from one request to the next inside a burst.
    // ------------------------------------------------------------------------
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    task automatic send_req(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
        t_deq_in req;
        int      gap;
        req.op    = op;
        req.value = value;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left != 0)
            burst_left--;
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    // extremes turn up often, the rest is uniform
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    // push_pct steers the fill level; clears only where asked
    function automatic logic [OP_W-1:0] random_op(input int push_pct, input bit allow_clear);
        int r;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        if (r < 91)
            return OP_QUERY;
        if (r < 97)
            return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        return allow_clear ? OP_CLEAR : OP_QUERY;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // empty-queue corners, extreme words, every op code, clear, head wrap
    task automatic test_directed();
        send_req(OP_QUERY, '0);
        send_req(OP_POP_FRONT, '0);             // underflow
        send_req(OP_POP_BACK, WORD_ONES);       // underflow
        send_req(OP_SPARE_6, WORD_MAX);
        send_req(OP_SPARE_7, WORD_MIN);
        send_req(OP_PUSH_BACK, WORD_MAX);
        send_req(OP_PUSH_FRONT, WORD_MIN);      // head wraps to the last slot
        send_req(OP_PUSH_BACK, '0);
        send_req(OP_PUSH_FRONT, WORD_ONES);
        send_req(OP_QUERY, 32'h1234_5678);
        send_req(OP_SPARE_6, '0);
        send_req(OP_POP_FRONT, WORD_ONES);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_FRONT, '0);             // back to empty
        send_req(OP_PUSH_BACK, 32'h5a5a_5a5a);
        send_req(OP_PUSH_FRONT, 32'ha5a5_a5a5);
        send_req(OP_CLEAR, WORD_ONES);          // old words stay in the array
        send_req(OP_QUERY, '0);
        send_req(OP_POP_BACK, '0);              // underflow after clear
        send_req(OP_PUSH_FRONT, 32'h0f0f_0f0f);
        send_req(OP_SPARE_7, '0);
        send_req(OP_POP_BACK, '0);
    endtask

    // fill to capacity from random ends, overflow both ends, drain to empty
    task automatic test_fill_to_full();
        send_req(OP_CLEAR, '0);
        repeat (DEPTH)
            send_req($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, random_word());
        send_req(OP_PUSH_FRONT, WORD_MAX);      // overflow
        send_req(OP_PUSH_BACK, WORD_MIN);       // overflow
        send_req(OP_QUERY, '0);
        repeat (DEPTH)
            send_req($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, random_word());
        send_req(OP_POP_FRONT, '0);             // underflow
    endtask

    // sink holds off while the source keeps offering, so the block backs up
    task automatic test_long_stall();
        gaps_on = 1'b0;
        hold_gen <= hold_gen + 1;
        repeat (40)
            send_req(random_op(60, 1'b0), random_word());
        gaps_on = 1'b1;
    endtask

    // phases of push-heavy, balanced and pop-heavy traffic walk the fill
    // level up and back down; every other phase runs without gaps
    task automatic test_random_mix();
        int push_pct [6] = '{92, 50, 8, 92, 55, 10};
        for (int ph = 0; ph < 6; ph++) begin
            gaps_on = ph[0];
            repeat (80)
                send_req(random_op(push_pct[ph], push_pct[ph] > 20 && push_pct[ph] < 80),
                         random_word());
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_to_full();
        test_long_stall();
        test_random_mix();

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_expect_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);   // catch any stray response

        if (fail_cnt == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[double_ended_queue] ERROR");
        $finish;
    end

endmodule
